// ----- design/vsv_pkg.sv -----
`default_nettype none

package vsv_pkg;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UP_A  = 8'h41;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LO_A  = 8'h61;
   localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

   localparam logic [1:0] PART_MAJOR = 2'd0;
   localparam logic [1:0] PART_MINOR = 2'd1;
   localparam logic [1:0] PART_PATCH = 2'd2;
   localparam logic [1:0] PART_TAIL  = 2'd3;

   // digit and identifier lengths saturate here
   localparam logic [1:0] LEN_SAT    = 2'd2;

   // wide enough for byte counters of up to 10 bits, used for saturation compares
   localparam int         WIDE_W     = 10;
   localparam logic [WIDE_W-1:0] OFFSET_MAX = WIDE_W'(63);

   localparam int         RSP_DATA_W = 112;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_code;
      logic       last_char;
   } vsv_byte_type;

   typedef struct packed {
      logic        valid_res;
      logic [31:0] major_number;
      logic [31:0] minor_number;
      logic [31:0] patch_number;
      logic        has_prerelease;
      logic [5:0]  prerelease_start;
      logic [5:0]  prerelease_length;
   } vsv_result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_digit(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_Z)) ||
             ((c >= CHAR_UP_A) && (c <= CHAR_UP_Z)) || (c == CHAR_DASH);
   endfunction

   function automatic logic [5:0] sat_offset(input logic [WIDE_W-1:0] v);
      return (v > OFFSET_MAX) ? 6'd63 : v[5:0];
   endfunction

endpackage

`default_nettype wire

// ----- design/vsv_in_reg.sv -----
`default_nettype none

module vsv_in_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,
   input  wire logic                 req_tlast,
   input  wire logic                 advance,
   output vsv_pkg::vsv_byte_type     held
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff;
   logic       last_ff;
   logic       accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign held.valid     = valid_ff;
   assign held.char_code = char_ff;
   assign held.last_char = last_ff;

endmodule

`default_nettype wire

// ----- design/vsv_scan.sv -----
`default_nettype none

module vsv_scan #(
   parameter int MAX_LEN = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire vsv_pkg::vsv_byte_type held,
   output vsv_pkg::vsv_result_type    result
);

   localparam int CNT_W = $clog2(MAX_LEN + 3);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [1:0]       part_index_ff, part_index_in;
   logic [31:0]      number_accum_ff, number_accum_in;
   logic             number_overflow_ff, number_overflow_in;
   logic [1:0]       digit_count_ff, digit_count_in;
   logic             first_digit_zero_ff, first_digit_zero_in;
   logic [31:0]      held_major_ff, held_major_in;
   logic [31:0]      held_minor_ff, held_minor_in;
   logic [1:0]       ident_length_ff, ident_length_in;
   logic             ident_all_digits_ff, ident_all_digits_in;
   logic             ident_first_zero_ff, ident_first_zero_in;
   logic             failed_ff, failed_in;
   logic [CNT_W-1:0] tail_begin_ff, tail_begin_in;

   logic [7:0]       c;
   logic [35:0]      times_ten;
   logic             part_ok, ident_ok;
   logic             fin_part_ok, fin_ident_ok;
   logic             ok;
   logic [CNT_W-1:0] count_next, tail_len;

   assign c = held.char_code;
   assign times_ten = {1'b0, number_accum_ff, 3'b000} + {3'b000, number_accum_ff, 1'b0}
                    + {32'd0, c[3:0]};

   assign part_ok  = (digit_count_ff != 2'd0) && !number_overflow_ff &&
                     !((digit_count_ff == vsv_pkg::LEN_SAT) && first_digit_zero_ff);
   assign ident_ok = (ident_length_ff != 2'd0) &&
                     !(ident_all_digits_ff && (ident_length_ff == vsv_pkg::LEN_SAT) &&
                       ident_first_zero_ff);

   assign count_next = (byte_count_ff <= CNT_LIMIT) ? byte_count_ff + CNT_W'(1)
                                                    : byte_count_ff;

   // per-byte state update, before the end-of-string clear
   always_comb begin
      part_index_in       = part_index_ff;
      number_accum_in     = number_accum_ff;
      number_overflow_in  = number_overflow_ff;
      digit_count_in      = digit_count_ff;
      first_digit_zero_in = first_digit_zero_ff;
      held_major_in       = held_major_ff;
      held_minor_in       = held_minor_ff;
      ident_length_in     = ident_length_ff;
      ident_all_digits_in = ident_all_digits_ff;
      ident_first_zero_in = ident_first_zero_ff;
      failed_in           = failed_ff;
      tail_begin_in       = tail_begin_ff;
      if (!failed_ff) begin
         priority if (c == vsv_pkg::CHAR_PLUS) begin
            failed_in = 1'b1;
         end else if (part_index_ff != vsv_pkg::PART_TAIL) begin
            priority if (vsv_pkg::is_digit(c)) begin
               if (digit_count_ff == 2'd0) begin
                  first_digit_zero_in = (c == vsv_pkg::CHAR_ZERO);
               end
               if (digit_count_ff != vsv_pkg::LEN_SAT) begin
                  digit_count_in = digit_count_ff + 2'd1;
               end
               if (times_ten[35:32] != 4'd0) begin
                  number_overflow_in = 1'b1;
               end
               number_accum_in = times_ten[31:0];
            end else if (c == vsv_pkg::CHAR_DOT) begin
               if (!part_ok || (part_index_ff == vsv_pkg::PART_PATCH)) begin
                  failed_in = 1'b1;
               end else begin
                  if (part_index_ff == vsv_pkg::PART_MAJOR) begin
                     held_major_in = number_accum_ff;
                  end else begin
                     held_minor_in = number_accum_ff;
                  end
                  part_index_in       = part_index_ff + 2'd1;
                  number_accum_in     = 32'd0;
                  number_overflow_in  = 1'b0;
                  digit_count_in      = 2'd0;
                  first_digit_zero_in = 1'b0;
               end
            end else if (c == vsv_pkg::CHAR_DASH) begin
               if (!part_ok || (part_index_ff != vsv_pkg::PART_PATCH)) begin
                  failed_in = 1'b1;
               end else begin
                  part_index_in       = vsv_pkg::PART_TAIL;
                  tail_begin_in       = byte_count_ff + CNT_W'(1);
                  ident_length_in     = 2'd0;
                  ident_all_digits_in = 1'b1;
                  ident_first_zero_in = 1'b0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end else begin
            priority if (c == vsv_pkg::CHAR_DOT) begin
               if (!ident_ok) begin
                  failed_in = 1'b1;
               end
               ident_length_in     = 2'd0;
               ident_all_digits_in = 1'b1;
               ident_first_zero_in = 1'b0;
            end else if (vsv_pkg::is_ident_char(c)) begin
               if (ident_length_ff == 2'd0) begin
                  ident_first_zero_in = (c == vsv_pkg::CHAR_ZERO);
               end
               if (ident_length_ff != vsv_pkg::LEN_SAT) begin
                  ident_length_in = ident_length_ff + 2'd1;
               end
               if (!vsv_pkg::is_digit(c)) begin
                  ident_all_digits_in = 1'b0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   assign fin_part_ok  = (digit_count_in != 2'd0) && !number_overflow_in &&
                         !((digit_count_in == vsv_pkg::LEN_SAT) && first_digit_zero_in);
   assign fin_ident_ok = (ident_length_in != 2'd0) &&
                         !(ident_all_digits_in && (ident_length_in == vsv_pkg::LEN_SAT) &&
                           ident_first_zero_in);

   always_comb begin
      ok = !failed_in && (count_next <= CNT_LIMIT);
      if (part_index_in == vsv_pkg::PART_TAIL) begin
         ok = ok && fin_ident_ok;
      end else begin
         ok = ok && (part_index_in == vsv_pkg::PART_PATCH) && fin_part_ok;
      end
   end

   assign tail_len = count_next - tail_begin_in;

   always_comb begin
      result = '0;
      if (ok) begin
         result.valid_res    = 1'b1;
         result.major_number = held_major_in;
         result.minor_number = held_minor_in;
         result.patch_number = number_accum_in;
         if (part_index_in == vsv_pkg::PART_TAIL) begin
            result.has_prerelease    = 1'b1;
            result.prerelease_start  =
               vsv_pkg::sat_offset(vsv_pkg::WIDE_W'(tail_begin_in));
            result.prerelease_length =
               vsv_pkg::sat_offset(vsv_pkg::WIDE_W'(tail_len));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && held.last_char)) begin
         byte_count_ff       <= '0;
         part_index_ff       <= vsv_pkg::PART_MAJOR;
         number_accum_ff     <= 32'd0;
         number_overflow_ff  <= 1'b0;
         digit_count_ff      <= 2'd0;
         first_digit_zero_ff <= 1'b0;
         held_major_ff       <= 32'd0;
         held_minor_ff       <= 32'd0;
         ident_length_ff     <= 2'd0;
         ident_all_digits_ff <= 1'b1;
         ident_first_zero_ff <= 1'b0;
         failed_ff           <= 1'b0;
         tail_begin_ff       <= '0;
      end else if (step) begin
         byte_count_ff       <= count_next;
         part_index_ff       <= part_index_in;
         number_accum_ff     <= number_accum_in;
         number_overflow_ff  <= number_overflow_in;
         digit_count_ff      <= digit_count_in;
         first_digit_zero_ff <= first_digit_zero_in;
         held_major_ff       <= held_major_in;
         held_minor_ff       <= held_minor_in;
         ident_length_ff     <= ident_length_in;
         ident_all_digits_ff <= ident_all_digits_in;
         ident_first_zero_ff <= ident_first_zero_in;
         failed_ff           <= failed_in;
         tail_begin_ff       <= tail_begin_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && held.last_char |=> byte_count_ff == '0 && !failed_ff &&
                                 part_index_ff == vsv_pkg::PART_MAJOR)
      else $error("scan state not cleared after last byte");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      !result.valid_res |-> result.major_number == 32'd0 &&
                            result.patch_number == 32'd0 && !result.has_prerelease &&
                            result.prerelease_length == 6'd0)
      else $error("invalid result carries nonzero fields");

   a_tail_has_start: assert property (@(posedge clock) disable iff (reset)
      part_index_ff == vsv_pkg::PART_TAIL |-> tail_begin_ff != '0 && digit_count_ff != 2'd0)
      else $error("tail entered without start offset or patch digits");

endmodule

`default_nettype wire

// ----- design/version_string_validator_unit.sv -----
// A result is loaded into the output register once its last byte has passed the input register and scan stage.
// Throughput: 1 byte per cycle, apart from the stall below; the per-byte update is one multiply-by-ten add plus flags.
// A result waiting on rsp_tready stalls input only when the next last byte reaches the
// scan stage; all other bytes keep flowing.
// Reset: synchronous; clears the input stage, the scan state and rsp_tvalid.
`default_nettype none

module version_string_validator_unit #(
   parameter int MAX_LEN = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] char_code
   input  wire logic         req_tlast,   // last_char
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [vsv_pkg::RSP_DATA_W-1:0] rsp_tdata
   // [0] valid_res, [32:1] major_number, [64:33] minor_number, [96:65] patch_number,
   // [97] has_prerelease, [103:98] prerelease_start, [109:104] prerelease_length
);

   vsv_pkg::vsv_byte_type   held;
   vsv_pkg::vsv_result_type result;
   vsv_pkg::vsv_result_type rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    advance, out_load;

   assign advance  = held.valid && (!held.last_char || !rsp_valid_ff || rsp_tready);
   assign out_load = advance && held.last_char;

   vsv_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .held       (held)
   );

   vsv_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .held   (held),
      .result (result)
   );

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00,
                        rsp_ff.prerelease_length,
                        rsp_ff.prerelease_start,
                        rsp_ff.has_prerelease,
                        rsp_ff.patch_number,
                        rsp_ff.minor_number,
                        rsp_ff.major_number,
                        rsp_ff.valid_res};

endmodule

`default_nettype wire
